/* design/edf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_pkg: shared types and constants
// Item and result structs, the cell control struct, register map and codes
// for the earliest-deadline-first feasibility checker.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int DEADLINE_W = 16;
  localparam int CAP_W      = 8;
  localparam int COUNT_OUT_W = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd1;

  // register index is paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [DEADLINE_W-1:0] deadline;
    logic                  tick_blocked;
  } in_item_t;

  typedef struct packed {
    logic                   missed;
    logic                   overflowed;
    logic [CAP_W-1:0]       served_now;
    logic [COUNT_OUT_W-1:0] pending_jobs;
    logic [DEADLINE_W-1:0]  tick_now;
  } out_item_t;

  // per-cycle command broadcast to every cell of the queue
  typedef struct packed {
    logic ins;   // sorted insert of the broadcast deadline
    logic pop;   // shift one place toward the head
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/edf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_cell: one slot of the sorted deadline queue
// Holds one deadline. On insert it keeps its value, takes the new deadline or
// takes its left neighbor's value; on pop it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module edf_cell
  import edf_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [DEADLINE_W-1:0] ins_data_i,
  input  wire logic [CNT_W-1:0]      count_i,
  input  wire logic [DEADLINE_W-1:0] prev_val_i,
  input  wire logic                  prev_le_i,
  input  wire logic [DEADLINE_W-1:0] next_val_i,
  output logic      [DEADLINE_W-1:0] val_o,
  output logic                       le_o
);

  logic [DEADLINE_W-1:0] val_q, val_d;
  logic                  occupied;

  assign occupied = count_i > CNT_W'(IDX);
  // occupied and not later than the incoming deadline: stays in place
  assign le_o     = occupied && (val_q <= ins_data_i);
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (le_o) begin
        val_d = val_q;
      end else if (prev_le_i) begin
        val_d = ins_data_i;
      end else begin
        val_d = prev_val_i;
      end
    end else if (ctrl_i.pop) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

/* design/edf_deadline_feasibility.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_deadline_feasibility: earliest-deadline-first feasibility checker
// Sorted queue as a row of cells, tick counter, sticky miss/overflow flags.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result_o for exactly one cycle with result_valid_o high, and must be caught
// then, since there is no back pressure. An add (the cell row inserts in
// place), a blocked tick and a tick that flags a miss complete in the idle
// state. An unblocked tick enters the serve state, where busy is high, and
// pops the head once per cycle until the queue is empty or capacity jobs are
// served, then completes. The result shows in the cycle after the item
// completes. A full queue drops the add and sets the sticky overflowed flag.
// ----------------------------------------------------------------------------
module edf_deadline_feasibility
  import edf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128,
  parameter int TICK_BITS   = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              item_i,
  output out_item_t                  result_o,
  output logic                       result_valid_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (TICK_BITS > DEADLINE_W) ? TICK_BITS : DEADLINE_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SERVE = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [TICK_BITS-1:0] tick_q, tick_d, tick_next;
  logic                 miss_q, miss_d;
  logic                 ovf_q, ovf_d;
  logic [CAP_W-1:0]     served_q, served_d;
  logic [CAP_W-1:0]     cap_q;
  out_item_t            result_q, result_d;
  logic                 result_valid_q, result_valid_d;

  cell_ctrl_t            ctrl;
  logic                  accept, full, head_late, finish, cfg_wr;
  logic [DEADLINE_W-1:0] cell_val [QUEUE_DEPTH];
  logic                  cell_le  [QUEUE_DEPTH];

  // ---- cell row, index 0 holds the earliest deadline ----
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DEADLINE_W-1:0] prev_val, next_val;
    logic                  prev_le;

    if (i == 0) begin : g_head
      assign prev_val = item_i.deadline;
      assign prev_le  = 1'b1;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_le  = cell_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    edf_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .ins_data_i (item_i.deadline),
      .count_i    (count_q),
      .prev_val_i (prev_val),
      .prev_le_i  (prev_le),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .le_o       (cell_le[i])
    );
  end

  // ---- control ----
  assign busy      = (state_q == ST_SERVE);
  assign accept    = start && !busy;
  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_late = (count_q != '0) && (CMP_W'(cell_val[0]) < CMP_W'(tick_q));
  assign tick_next = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    tick_d   = tick_q;
    miss_d   = miss_q;
    ovf_d    = ovf_q;
    served_d = served_q;
    ctrl     = '0;
    finish   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          served_d = '0;
          if (item_i.func == FUNC_ADD) begin
            finish = 1'b1;
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              ctrl.ins = 1'b1;
              count_d  = count_q + 1'b1;
            end
          end else if (item_i.tick_blocked) begin
            finish = 1'b1;
            tick_d = tick_next;
          end else if (head_late) begin
            finish = 1'b1;
            miss_d = 1'b1;
            tick_d = tick_next;
          end else begin
            state_d = ST_SERVE;
          end
        end
      end
      ST_SERVE: begin
        if ((count_q != '0) && (served_q < cap_q)) begin
          ctrl.pop = 1'b1;
          count_d  = count_q - 1'b1;
          served_d = served_q + 1'b1;
        end else begin
          finish  = 1'b1;
          tick_d  = tick_next;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    result_valid_d = finish;
    result_d       = result_q;
    if (finish) begin
      result_d.missed       = miss_d;
      result_d.overflowed   = ovf_d;
      result_d.served_now   = served_d;
      result_d.pending_jobs = COUNT_OUT_W'(count_d);
      result_d.tick_now     = DEADLINE_W'(tick_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      tick_q         <= '0;
      miss_q         <= 1'b0;
      ovf_q          <= 1'b0;
      served_q       <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      tick_q         <= tick_d;
      miss_q         <= miss_d;
      ovf_q          <= ovf_d;
      served_q       <= served_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

endmodule
`default_nettype wire

/* design/edf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_checker: port-level checks for the feasibility checker
// Result timing around transfers and stickiness of the status flags.
// ----------------------------------------------------------------------------
module edf_checker
  import edf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  item_i,
  input wire out_item_t result_o,
  input wire logic      result_valid_o
);

  logic accept_add;
  logic miss_seen_q, ovf_seen_q;

  assign accept_add = start && !busy && (item_i.func == FUNC_ADD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_seen_q <= 1'b0;
      ovf_seen_q  <= 1'b0;
    end else if (result_valid_o) begin
      miss_seen_q <= miss_seen_q || result_o.missed;
      ovf_seen_q  <= ovf_seen_q || result_o.overflowed;
    end
  end

  a_add_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(accept_add) |-> result_valid_o)
    else $error("add transfer gave no result in the next cycle");

  a_add_serves_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(accept_add) |-> result_o.served_now == '0)
    else $error("add result reports served jobs");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result strobe while serving");

  a_miss_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && miss_seen_q |-> result_o.missed)
    else $error("miss flag cleared");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ovf_seen_q |-> result_o.overflowed)
    else $error("overflow flag cleared");

endmodule

bind edf_deadline_feasibility edf_checker u_edf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_o       (result_o),
  .result_valid_o (result_valid_o)
);
`default_nettype wire
